[hdl/att_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_pkg
// Types, codes and tables shared by the text terminal controller and datapath.
// ----------------------------------------------------------------------------
package att_pkg;

    localparam int MAX_COLS  = 80;
    localparam int MAX_LINES = 25;
    localparam int TAB_WIDTH = 8;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_LF_F  = 8'h66;
    localparam logic [7:0] CH_M     = 8'h6D;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;
    localparam logic [7:0] PARAM_MAX  = 8'd255;

    localparam logic [1:0] REG_COLS    = 2'd0;
    localparam logic [1:0] REG_LINES   = 2'd1;
    localparam logic [1:0] REG_DEFATTR = 2'd2;
    localparam logic [1:0] REG_HIDDEN  = 2'd3;

    localparam logic OP_PUT = 1'b0;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE,
        K_READ,
        K_PRINT,
        K_TAB,
        K_NL,
        K_CLEAR
    } t_kind;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RD,
        S_RDWAIT,
        S_PRINT,
        S_NL,
        S_SCR_RD,
        S_SCR_WR,
        S_BLANK,
        S_NLDONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic init;
        logic decode;
        logic rd_issue;
        logic rd_take;
        logic print;
        logic nl;
        logic scr_rd;
        logic scr_wr;
        logic blank;
        logic cnt_dec;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  init_last;
        logic  wrap;
        logic  tab_more;
        logic  scroll_need;
        logic  copy_empty;
        logic  copy_last;
        logic  blank_last;
        logic  cnt_more;
    } t_sts;

    function automatic logic [2:0] att_colour(input logic [2:0] code);
        logic [2:0] res;
        case (code)
            3'd0: res = 3'd0;
            3'd1: res = 3'd4;
            3'd2: res = 3'd2;
            3'd3: res = 3'd6;
            3'd4: res = 3'd1;
            3'd5: res = 3'd5;
            3'd6: res = 3'd3;
            default: res = 3'd7;
        endcase
        return res;
    endfunction

endpackage

[hdl/att_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_if
// Valid/ready channels of the text terminal: character in, result out, config.
// ----------------------------------------------------------------------------
interface att_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  char_in;
    logic [10:0] read_index;
    modport source (output valid, opcode, char_in, read_index, input ready);
    modport sink (input valid, opcode, char_in, read_index, output ready);
endinterface

interface att_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_address;
    logic        cursor_valid;
    logic [7:0]  current_attribute;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    modport source (output valid, cursor_col, cursor_row, cursor_address, cursor_valid,
                    current_attribute, cell_char, cell_attr, input ready);
    modport sink (input valid, cursor_col, cursor_row, cursor_address, cursor_valid,
                  current_attribute, cell_char, cell_attr, output ready);
endinterface

interface att_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/att_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_ctrl
// Sequencer: store fill after reset, per-character steps, scroll and clear.
// ----------------------------------------------------------------------------
module att_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    input  att_pkg::t_sts i_sts,
    output att_pkg::t_cmd o_cmd
);
    import att_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.kind)
                    K_READ:  n_state = S_RD;
                    K_PRINT: n_state = S_PRINT;
                    K_TAB:   n_state = S_PRINT;
                    K_NL:    n_state = S_NL;
                    K_CLEAR: n_state = S_BLANK;
                    default: n_state = S_OUT;
                endcase
            end
            S_RD:     n_state = S_RDWAIT;
            S_RDWAIT: n_state = S_OUT;
            S_PRINT: begin
                if (i_sts.wrap) n_state = S_NL;
                else if (i_sts.tab_more) n_state = S_PRINT;
                else n_state = S_OUT;
            end
            S_NL: begin
                if (!i_sts.scroll_need) n_state = S_NLDONE;
                else if (i_sts.copy_empty) n_state = S_BLANK;
                else n_state = S_SCR_RD;
            end
            S_SCR_RD: n_state = S_SCR_WR;
            S_SCR_WR: begin
                if (i_sts.copy_last) n_state = S_BLANK;
                else n_state = S_SCR_RD;
            end
            S_BLANK: begin
                if (i_sts.blank_last) n_state = S_NLDONE;
            end
            S_NLDONE: begin
                if (i_sts.cnt_more) n_state = S_NL;
                else n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT:   o_cmd.init = 1'b1;
            S_IDLE:   o_cmd.in_ready = 1'b1;
            S_DECODE: o_cmd.decode = 1'b1;
            S_RD:     o_cmd.rd_issue = 1'b1;
            S_RDWAIT: o_cmd.rd_take = 1'b1;
            S_PRINT:  o_cmd.print = 1'b1;
            S_NL:     o_cmd.nl = 1'b1;
            S_SCR_RD: o_cmd.scr_rd = 1'b1;
            S_SCR_WR: o_cmd.scr_wr = 1'b1;
            S_BLANK:  o_cmd.blank = 1'b1;
            S_NLDONE: o_cmd.cnt_dec = 1'b1;
            S_OUT:    o_cmd.out_valid = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

endmodule

[hdl/att_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_dp
// Datapath: screen store, cursor, attribute, escape parser and sweep address.
// ----------------------------------------------------------------------------
module att_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  att_pkg::t_cmd i_cmd,
    output att_pkg::t_sts o_sts,
    input  logic          i_opcode,
    input  logic [7:0]    i_char_in,
    input  logic [10:0]   i_read_index,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output logic [6:0]    o_cursor_col,
    output logic [4:0]    o_cursor_row,
    output logic [10:0]   o_cursor_address,
    output logic          o_cursor_valid,
    output logic [7:0]    o_current_attribute,
    output logic [7:0]    o_cell_char,
    output logic [7:0]    o_cell_attr
);
    import att_pkg::*;

    localparam int STORE     = MAX_COLS * MAX_LINES;
    localparam int AW        = $clog2(STORE);
    localparam int CW        = $clog2(STORE + 1);
    localparam int RST_COLS  = (MAX_COLS < 80) ? MAX_COLS : 80;
    localparam int RST_LINES = (MAX_LINES < 25) ? MAX_LINES : 25;

    logic [15:0]   mem [STORE];
    logic [15:0]   r_rdata;

    logic          r_op;
    logic [7:0]    r_char;
    logic [10:0]   r_ridx;
    logic [6:0]    r_cols;
    logic [4:0]    r_lines;
    logic [7:0]    r_defattr;
    logic          r_hidden;
    logic [6:0]    r_col;
    logic [4:0]    r_row;
    logic [7:0]    r_attr;
    t_phase        r_phase;
    logic          r_spf;
    logic [7:0]    r_p1;
    logic [7:0]    r_p2;
    logic          r_bright;
    logic [7:0]    r_cnt;
    logic [7:0]    r_wchar;
    logic [7:0]    r_target;
    logic [CW-1:0] r_addr;
    logic [CW-1:0] r_end;
    logic [CW-1:0] r_limit;
    logic [15:0]   r_cell;

    t_kind         d_kind;
    t_phase        d_phase;
    logic          d_spf;
    logic [7:0]    d_p1;
    logic [7:0]    d_p2;
    logic [6:0]    d_col;
    logic [4:0]    d_row;
    logic [7:0]    d_attr;
    logic          d_bright;
    logic [7:0]    d_cnt;
    logic [7:0]    d_wchar;
    logic [7:0]    d_target;
    logic [11:0]   d_acc;
    logic [7:0]    d_nn;
    logic [7:0]    d_mm;
    logic [7:0]    d_sgr;
    logic [2:0]    d_clr;

    logic [CW-1:0] w_area;
    logic [AW-1:0] w_cur;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [6:0]    w_ncols;
    logic [4:0]    w_nlines;
    logic          w_ridx_ok;

    assign w_area = CW'(r_lines * r_cols);
    assign w_cur  = AW'(r_row * r_cols + r_col);
    assign w_ridx_ok = 32'(r_ridx) < STORE;

    always_comb begin
        d_kind   = K_NONE;
        d_phase  = r_phase;
        d_spf    = r_spf;
        d_p1     = r_p1;
        d_p2     = r_p2;
        d_col    = r_col;
        d_row    = r_row;
        d_attr   = r_attr;
        d_bright = r_bright;
        d_cnt    = 8'd1;
        d_wchar  = r_char;
        d_target = 8'(({1'b0, r_col} / TAB_WIDTH + 8'd1) * TAB_WIDTH);
        d_acc    = '0;
        d_nn     = r_p1;
        d_mm     = r_p2;
        d_sgr    = '0;
        d_clr    = '0;
        if (r_op != OP_PUT) begin
            d_kind = K_READ;
        end else begin
            case (r_phase)
                PH_PARAM: begin
                    if (r_char >= CH_0 && r_char <= CH_9) begin
                        d_acc = 12'((r_spf ? r_p2 : r_p1) * 10) + 12'(r_char - CH_0);
                        if (d_acc > 12'(PARAM_MAX)) d_acc = 12'(PARAM_MAX);
                        if (r_spf) d_p2 = d_acc[7:0];
                        else d_p1 = d_acc[7:0];
                    end else begin
                        d_phase = PH_TEXT;
                        d_spf   = 1'b0;
                        if (r_p1 == 8'd0 && r_char != CH_J && r_char != CH_M) d_nn = 8'd1;
                        if (r_p2 == 8'd0) d_mm = 8'd1;
                        d_p1 = d_nn;
                        d_p2 = d_mm;
                        case (r_char)
                            CH_A: begin
                                d_row = ({3'b0, r_row} > d_nn) ? 5'(r_row - d_nn[4:0]) : 5'd0;
                            end
                            CH_B: begin
                                if (9'(r_row) + 9'(d_nn) < 9'(r_lines))
                                    d_row = 5'(9'(r_row) + 9'(d_nn));
                                else d_row = r_lines - 5'd1;
                            end
                            CH_C: begin
                                if (9'(r_col) + 9'(d_nn) < 9'(r_cols))
                                    d_col = 7'(9'(r_col) + 9'(d_nn));
                                else d_col = r_cols - 7'd1;
                            end
                            CH_D: begin
                                d_col = ({1'b0, r_col} > d_nn) ? 7'(r_col - d_nn[6:0]) : 7'd0;
                            end
                            CH_E: begin
                                d_kind = K_NL;
                                d_cnt  = d_nn;
                            end
                            CH_F: begin
                                d_row = ({3'b0, r_row} > d_nn) ? 5'(r_row - d_nn[4:0]) : 5'd0;
                                d_col = '0;
                            end
                            CH_G: begin
                                if (d_nn >= 8'd1 && d_nn <= {1'b0, r_cols})
                                    d_col = 7'(d_nn - 8'd1);
                            end
                            CH_H, CH_LF_F: begin
                                if (d_nn >= 8'd1 && d_nn <= {3'b0, r_lines})
                                    d_row = 5'(d_nn - 8'd1);
                                if (d_mm >= 8'd1 && d_mm <= {1'b0, r_cols})
                                    d_col = 7'(d_mm - 8'd1);
                            end
                            CH_SEMI: begin
                                d_phase = PH_PARAM;
                                d_spf   = 1'b1;
                                d_p2    = '0;
                            end
                            CH_M: begin
                                if (d_nn == 8'd0) begin
                                    d_attr = r_defattr;
                                end else if (d_nn == 8'd1) begin
                                    d_bright = 1'b1;
                                end else if (d_nn == 8'd2) begin
                                    d_bright = 1'b0;
                                end else if (d_nn >= SGR_FG_LO && d_nn <= SGR_FG_HI) begin
                                    d_sgr  = d_nn - SGR_FG_LO;
                                    d_clr  = att_colour(d_sgr[2:0]);
                                    d_attr = {r_attr[7:4], r_bright, d_clr};
                                end else if (d_nn >= SGR_BG_LO && d_nn <= SGR_BG_HI) begin
                                    d_sgr  = d_nn - SGR_BG_LO;
                                    d_clr  = att_colour(d_sgr[2:0]);
                                    d_attr = {r_bright, d_clr, r_attr[3:0]};
                                end
                            end
                            CH_J: begin
                                if (d_nn == 8'd2) begin
                                    d_kind = K_CLEAR;
                                    d_col  = '0;
                                    d_row  = '0;
                                end
                            end
                            default: d_kind = K_NONE;
                        endcase
                    end
                end
                PH_ESC: begin
                    if (r_char == CH_LBRK) begin
                        d_phase = PH_PARAM;
                        d_p1    = '0;
                        d_p2    = '0;
                    end else begin
                        d_phase = PH_TEXT;
                    end
                end
                default: begin
                    if (r_char == CH_ESC) begin
                        d_phase = PH_ESC;
                    end else if (r_char == CH_LF || r_char == CH_CR) begin
                        d_kind = K_NL;
                    end else if (r_char == CH_TAB) begin
                        d_wchar = CH_SPACE;
                        d_kind  = (d_target >= {1'b0, r_cols}) ? K_NL : K_TAB;
                    end else begin
                        d_kind = K_PRINT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.kind        = d_kind;
        o_sts.init_last   = 32'(r_addr) == STORE - 1;
        o_sts.wrap        = {1'b0, r_col} + 8'd1 >= {1'b0, r_cols};
        o_sts.tab_more    = (r_wchar == CH_SPACE) && (8'(r_col) + 8'd1 < r_target)
                            && (r_target != 8'd0);
        o_sts.scroll_need = r_row + 5'd1 >= r_lines;
        o_sts.copy_empty  = r_lines == 5'd1;
        o_sts.copy_last   = r_addr + CW'(1) == r_end;
        o_sts.blank_last  = r_addr + CW'(1) == r_limit;
        o_sts.cnt_more    = r_cnt > 8'd1;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr[AW-1:0];
        w_wdata = {ATTR_RESET, CH_SPACE};
        if (i_cmd.init) begin
            w_we = 1'b1;
        end else if (i_cmd.print) begin
            w_we    = 1'b1;
            w_waddr = w_cur;
            w_wdata = {r_attr, r_wchar};
        end else if (i_cmd.scr_wr) begin
            w_we    = 1'b1;
            w_wdata = r_rdata;
        end else if (i_cmd.blank) begin
            w_we    = 1'b1;
            w_wdata = {r_attr, CH_SPACE};
        end
        w_raddr = i_cmd.rd_issue ? AW'(r_ridx) : AW'(r_addr + CW'(r_cols));
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rdata <= mem[w_raddr];
    end

    always_comb begin
        w_ncols = i_cfg_data[6:0];
        if (w_ncols == 7'd0) w_ncols = 7'd1;
        else if ({1'b0, i_cfg_data[6:0]} > 8'(MAX_COLS)) w_ncols = 7'(MAX_COLS);
        w_nlines = i_cfg_data[4:0];
        if (w_nlines == 5'd0) w_nlines = 5'd1;
        else if ({2'b0, i_cfg_data[4:0]} > 7'(MAX_LINES)) w_nlines = 5'(MAX_LINES);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready) begin
            r_op   <= i_opcode;
            r_char <= i_char_in;
            r_ridx <= i_read_index;
        end
        if (i_cmd.decode) begin
            r_wchar  <= d_wchar;
            r_target <= (d_kind == K_TAB) ? d_target : 8'd0;
        end
        if (i_cmd.decode) r_cell <= '0;
        else if (i_cmd.rd_take) r_cell <= w_ridx_ok ? r_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= 7'(RST_COLS);
            r_lines   <= 5'(RST_LINES);
            r_defattr <= ATTR_RESET;
            r_hidden  <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_attr    <= ATTR_RESET;
            r_phase   <= PH_TEXT;
            r_spf     <= 1'b0;
            r_p1      <= '0;
            r_p2      <= '0;
            r_bright  <= 1'b0;
            r_cnt     <= '0;
            r_addr    <= '0;
            r_end     <= '0;
            r_limit   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_COLS: begin
                        r_cols <= w_ncols;
                        if (r_col >= w_ncols) r_col <= w_ncols - 7'd1;
                    end
                    REG_LINES: begin
                        r_lines <= w_nlines;
                        if (r_row >= w_nlines) r_row <= w_nlines - 5'd1;
                    end
                    REG_DEFATTR: r_defattr <= i_cfg_data;
                    REG_HIDDEN:  r_hidden <= i_cfg_data[0];
                    default: r_hidden <= r_hidden;
                endcase
            end
            if (i_cmd.init) r_addr <= r_addr + CW'(1);
            if (i_cmd.decode) begin
                r_phase  <= d_phase;
                r_spf    <= d_spf;
                r_p1     <= d_p1;
                r_p2     <= d_p2;
                r_col    <= d_col;
                r_row    <= d_row;
                r_attr   <= d_attr;
                r_bright <= d_bright;
                r_cnt    <= d_cnt;
                if (d_kind == K_CLEAR) begin
                    r_addr  <= '0;
                    r_limit <= w_area;
                end
            end
            if (i_cmd.print) r_col <= r_col + 7'd1;
            if (i_cmd.nl) begin
                r_col <= '0;
                if (o_sts.scroll_need) begin
                    r_addr  <= '0;
                    r_end   <= w_area - CW'(r_cols);
                    r_limit <= w_area;
                end else begin
                    r_row <= r_row + 5'd1;
                end
            end
            if (i_cmd.scr_wr || i_cmd.blank) r_addr <= r_addr + CW'(1);
            if (i_cmd.cnt_dec && o_sts.cnt_more) r_cnt <= r_cnt - 8'd1;
        end
    end

    assign o_cursor_col        = r_col;
    assign o_cursor_row        = r_row;
    assign o_cursor_address    = 11'(r_row * MAX_COLS + r_col);
    assign o_cursor_valid      = ~r_hidden;
    assign o_current_attribute = r_attr;
    assign o_cell_char         = r_cell[7:0];
    assign o_cell_attr         = r_cell[15:8];

endmodule

[hdl/ansi_text_terminal_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer
// Text terminal with ANSI escape parsing over a character/attribute store.
// ----------------------------------------------------------------------------
// Channels: i_in takes one transaction per put or read item, o_out returns
// exactly one result transaction per item, i_cfg writes the four window and
// attribute registers (always ready; write only while the block is idle).
// One item at a time: i_in.ready is high only while no item is in progress.
// Bytes that only move the parser, cursor or attribute go from decode to
// o_out; a printable byte adds a print step, a read the read issue and take
// steps, a new line the new-line and count steps. A wrapping byte runs a new
// line after its print, a tab prints spaces to the next tab stop and a clear
// screen blanks lines*cols cells. A scrolling new line copies (lines-1)*cols
// cells up and blanks the last line; ESC [ n E makes n new lines. The store
// has one write and one registered read port; the fill and blank sweeps run
// one cell per cycle and a scroll reads each copied cell in S_SCR_RD, then
// writes it in S_SCR_WR. Reset fills the store with spaces in attribute 7,
// one cell per cycle, all MAX_COLS*MAX_LINES cells (2000 at the defaults);
// no item is accepted until the fill is done. A result held by a stalled
// receiver stays on o_out and the next item waits until it is taken.
// ----------------------------------------------------------------------------
module ansi_text_terminal_writer (
    input  logic i_clk,
    input  logic i_rst_n,
    att_in_if.sink    i_in,
    att_out_if.source o_out,
    att_cfg_if.sink   i_cfg
);
    import att_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign i_in.ready  = w_cmd.in_ready;
    assign o_out.valid = w_cmd.out_valid;
    assign i_cfg.ready = 1'b1;

    att_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    att_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_opcode            (i_in.opcode),
        .i_char_in           (i_in.char_in),
        .i_read_index        (i_in.read_index),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .o_cursor_col        (o_out.cursor_col),
        .o_cursor_row        (o_out.cursor_row),
        .o_cursor_address    (o_out.cursor_address),
        .o_cursor_valid      (o_out.cursor_valid),
        .o_current_attribute (o_out.current_attribute),
        .o_cell_char         (o_out.cell_char),
        .o_cell_attr         (o_out.cell_attr)
    );

endmodule
